// ----- src/lcal_pkg.sv -----
// package for the lowest common ancestor engine
// shared item types, mode codes, datapath commands and status; no dependencies
`timescale 1ns / 1ps

package lcal_pkg;

	localparam int ID_W = 11;
	localparam int MAX_NODES_DEF = 1024;
	localparam int LOG_LEVELS_DEF = 10;

	localparam logic [1:0] MODE_EDGE  = 2'd0;
	localparam logic [1:0] MODE_BUILD = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	typedef struct packed {
		logic [1:0]      mode;
		logic [ID_W-1:0] node_a;
		logic [ID_W-1:0] node_b;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0] ancestor;
		logic            error;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_EDGE_WR,
		OP_CLR,
		OP_ROOT,
		OP_POP_RD,
		OP_POP_GET,
		OP_DX_GET,
		OP_E_RD,
		OP_E_GET,
		OP_E_CHK,
		OP_JINIT,
		OP_J0_RD,
		OP_J0_WR,
		OP_JK_RD1,
		OP_JK_RD2,
		OP_JK_WR,
		OP_Q_RDA,
		OP_Q_RDB,
		OP_Q_ORD,
		OP_L1_RD,
		OP_L1_GET,
		OP_L2_RDU,
		OP_L2_RDV,
		OP_L2_GET,
		OP_PAR_RD,
		OP_OUT_PAR,
		OP_OUT_EQ,
		OP_OUT_ERR
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic clr_last;
		logic q_empty;
		logic e_end;
		logic i_last;
		logic k_last;
		logic lvl_zero;
		logic u_eq_v;
	} dp_stat_t;

endpackage

// ----- src/lcal_datapath.sv -----
// datapath of the lowest common ancestor engine: edge, search, parent, depth
// and jump memories with their counters; depends on lcal_pkg
`timescale 1ns / 1ps

module lcal_datapath import lcal_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int LOG_LEVELS = LOG_LEVELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dp_cmd_t         cmd,
	input  in_item_t        item,
	input  logic            cfg_we,
	input  logic [ID_W-1:0] cfg_wdata,
	output dp_stat_t        stat,
	output out_item_t       result,
	output logic            done
);

	localparam int AW = $clog2(MAX_NODES + 1);
	localparam int EW = $clog2(MAX_NODES);
	localparam int DW = EW;
	localparam int KW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
	localparam int JA = KW + AW;

	logic [2*ID_W-1:0] edge_mem [2**EW];
	logic [ID_W-1:0]   queue_mem [2**EW];
	logic              vis_mem [2**AW];
	logic [ID_W-1:0]   par_mem [2**AW];
	logic [DW-1:0]     dep_mem [2**AW];
	logic [ID_W-1:0]   jump_mem [2**JA];

	logic [2*ID_W-1:0] erd;
	logic [ID_W-1:0]   qrd, prd, jrd;
	logic              vrd;
	logic [DW-1:0]     drd;

	logic [ID_W-1:0] n_q, a_q, b_q, x_q, y_q, mid_q, u_q, v_q, pu_q;
	logic [EW-1:0]   etot_q, e_q;
	logic [EW:0]     head_q, tail_q;
	logic [AW-1:0]   clr_q, i_q;
	logic [DW-1:0]   dx_q, da_q, rem_q;
	logic [KW-1:0]   k_q, top_q, lvl_q;
	logic            ok_q, done_q;
	out_item_t       result_q;

	// edge match and order of query depths
	logic [ID_W-1:0] e0, e1, y_c;
	logic            ok_c, swap_c;
	logic [DW-1:0]   du_c, dv_c;
	logic [KW-1:0]   top_c;
	logic [31:0]     pow_c;

	always_comb begin
		e0 = erd[2*ID_W-1:ID_W];
		e1 = erd[ID_W-1:0];
		ok_c = 1'b1;
		if (e0 == x_q) begin
			y_c = e1;
		end else if (e1 == x_q) begin
			y_c = e0;
		end else begin
			y_c = e1;
			ok_c = 1'b0;
		end
		if (y_c == '0 || y_c > n_q) begin
			ok_c = 1'b0;
		end
		swap_c = da_q < drd;
		du_c = swap_c ? drd : da_q;
		dv_c = swap_c ? da_q : drd;
		top_c = '0;
		for (int t = 1; t < LOG_LEVELS; t++) begin
			if (32'(du_c) >= (32'd1 << t)) begin
				top_c = KW'(t);
			end
		end
		pow_c = 32'd1 << lvl_q;
	end

	// memory address and write control
	logic              q_we, v_we, pd_we, j_we;
	logic [EW-1:0]     q_wa;
	logic [ID_W-1:0]   q_wd, p_wd, j_wd;
	logic [AW-1:0]     v_wa, pd_wa, v_ra, p_ra, d_ra;
	logic              v_wd;
	logic [DW-1:0]     d_wd;
	logic [JA-1:0]     j_wa, j_ra;
	logic [KW-1:0]     km1;

	always_comb begin
		km1 = k_q - 1'b1;
		q_we = 1'b0;  q_wa = '0;  q_wd = '0;
		v_we = 1'b0;  v_wa = '0;  v_wd = 1'b0;
		pd_we = 1'b0; pd_wa = '0; p_wd = '0; d_wd = '0;
		j_we = 1'b0;  j_wa = '0;  j_wd = '0;
		v_ra = AW'(y_c);
		p_ra = i_q;
		d_ra = AW'(qrd);
		j_ra = {lvl_q, AW'(u_q)};
		case (cmd.op)
			OP_CLR: begin
				v_we = 1'b1; v_wa = clr_q;
				pd_we = 1'b1; pd_wa = clr_q;
			end
			OP_ROOT: begin
				q_we = 1'b1; q_wd = ID_W'(1);
				v_we = 1'b1; v_wa = AW'(1); v_wd = 1'b1;
			end
			OP_E_CHK: begin
				if (ok_q && !vrd) begin
					v_we = 1'b1; v_wa = AW'(y_q); v_wd = 1'b1;
					pd_we = 1'b1; pd_wa = AW'(y_q); p_wd = x_q; d_wd = dx_q + 1'b1;
					if (32'(tail_q) < MAX_NODES) begin
						q_we = 1'b1; q_wa = tail_q[EW-1:0]; q_wd = y_q;
					end
				end
			end
			OP_J0_WR: begin
				j_we = 1'b1; j_wa = {KW'(0), i_q}; j_wd = prd;
			end
			OP_JK_RD1: j_ra = {km1, i_q};
			OP_JK_RD2: j_ra = {km1, AW'(jrd)};
			OP_JK_WR: begin
				j_we = 1'b1; j_wa = {k_q, i_q};
				j_wd = (mid_q != '0) ? jrd : '0;
			end
			OP_Q_RDA: d_ra = AW'(a_q);
			OP_Q_RDB: d_ra = AW'(b_q);
			OP_L2_RDV: j_ra = {lvl_q, AW'(v_q)};
			OP_PAR_RD: p_ra = AW'(u_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EDGE_WR && 32'(etot_q) < MAX_NODES - 1) begin
			edge_mem[etot_q] <= {a_q, b_q};
		end
		erd <= edge_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_wa] <= q_wd;
		end
		qrd <= queue_mem[head_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vis_mem[v_wa] <= v_wd;
		end
		vrd <= vis_mem[v_ra];
	end

	always_ff @(posedge clk) begin
		if (pd_we) begin
			par_mem[pd_wa] <= p_wd;
			dep_mem[pd_wa] <= d_wd;
		end
		prd <= par_mem[p_ra];
		drd <= dep_mem[d_ra];
	end

	always_ff @(posedge clk) begin
		if (j_we) begin
			jump_mem[j_wa] <= j_wd;
		end
		jrd <= jump_mem[j_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= ID_W'(2);
			etot_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_wdata < ID_W'(2)) begin
					n_q <= ID_W'(2);
				end else if (32'(cfg_wdata) > MAX_NODES) begin
					n_q <= ID_W'(MAX_NODES);
				end else begin
					n_q <= cfg_wdata;
				end
			end
			if (cmd.op == OP_EDGE_WR && 32'(etot_q) < MAX_NODES - 1) begin
				etot_q <= etot_q + 1'b1;
			end
			done_q <= (cmd.op == OP_OUT_PAR) || (cmd.op == OP_OUT_EQ) ||
				(cmd.op == OP_OUT_ERR);
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q <= item.node_a;
			b_q <= item.node_b;
			clr_q <= '0;
		end
		case (cmd.op)
			OP_CLR: clr_q <= clr_q + 1'b1;
			OP_ROOT: begin
				head_q <= '0;
				tail_q <= (EW+1)'(1);
			end
			OP_POP_RD: head_q <= head_q + 1'b1;
			OP_POP_GET: begin
				x_q <= qrd;
				e_q <= '0;
			end
			OP_DX_GET: dx_q <= drd;
			OP_E_GET: begin
				y_q <= y_c;
				ok_q <= ok_c;
			end
			OP_E_CHK: begin
				e_q <= e_q + 1'b1;
				if (ok_q && !vrd && 32'(tail_q) < MAX_NODES) begin
					tail_q <= tail_q + 1'b1;
				end
			end
			OP_JINIT: begin
				i_q <= AW'(1);
				k_q <= KW'(1);
			end
			OP_J0_WR: i_q <= stat.i_last ? AW'(1) : i_q + 1'b1;
			OP_JK_RD2: mid_q <= jrd;
			OP_JK_WR: begin
				if (stat.i_last) begin
					i_q <= AW'(1);
					k_q <= k_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			OP_Q_RDB: da_q <= drd;
			OP_Q_ORD: begin
				u_q <= swap_c ? b_q : a_q;
				v_q <= swap_c ? a_q : b_q;
				rem_q <= du_c - dv_c;
				top_q <= top_c;
				lvl_q <= top_c;
			end
			OP_L1_GET: begin
				if (32'(rem_q) >= pow_c) begin
					u_q <= jrd;
					rem_q <= rem_q - DW'(pow_c);
				end
				lvl_q <= (lvl_q == '0) ? top_q : lvl_q - 1'b1;
			end
			OP_L2_RDV: pu_q <= jrd;
			OP_L2_GET: begin
				if (pu_q != '0 && pu_q != jrd) begin
					u_q <= pu_q;
					v_q <= jrd;
				end
				lvl_q <= lvl_q - 1'b1;
			end
			OP_OUT_PAR: result_q <= '{ancestor: prd, error: 1'b0};
			OP_OUT_EQ: result_q <= '{ancestor: u_q, error: 1'b0};
			OP_OUT_ERR: result_q <= '{ancestor: '0, error: 1'b1};
			default: ;
		endcase
	end

	always_comb begin
		stat.bad = (a_q == '0) || (a_q > n_q) || (b_q == '0) || (b_q > n_q);
		stat.clr_last = 32'(clr_q) == MAX_NODES;
		stat.q_empty = head_q == tail_q;
		stat.e_end = e_q == etot_q;
		stat.i_last = 32'(i_q) == 32'(n_q);
		stat.k_last = 32'(k_q) == LOG_LEVELS - 1;
		stat.lvl_zero = lvl_q == '0;
		stat.u_eq_v = u_q == v_q;
	end

	assign result = result_q;
	assign done = done_q;

endmodule

// ----- src/lcal_ctrl.sv -----
// sequencer of the lowest common ancestor engine: issues one datapath
// command per cycle from datapath status; depends on lcal_pkg
`timescale 1ns / 1ps

module lcal_ctrl import lcal_pkg::*; #(
	parameter int LOG_LEVELS = LOG_LEVELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] mode,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy
);

	typedef enum logic [4:0] {
		S_IDLE, S_EDGE, S_CLR, S_ROOT, S_QTEST, S_POP, S_POPG, S_DXG,
		S_ETEST, S_ERD, S_EGET, S_ECHK, S_JINIT, S_J0RD, S_J0WR,
		S_JKRD1, S_JKRD2, S_JKWR, S_QCHK, S_QRDA, S_QRDB, S_QORD,
		S_L1RD, S_L1G, S_CMP, S_L2RU, S_L2RV, S_L2G, S_PRD, S_OPAR,
		S_OEQ, S_OERR
	} state_t;

	state_t state_q, nxt;
	dp_op_t op_q;
	logic   busy_q;
	logic   accept;

	function automatic dp_op_t op_for(state_t s);
		case (s)
			S_EDGE:  return OP_EDGE_WR;
			S_CLR:   return OP_CLR;
			S_ROOT:  return OP_ROOT;
			S_POP:   return OP_POP_RD;
			S_POPG:  return OP_POP_GET;
			S_DXG:   return OP_DX_GET;
			S_ERD:   return OP_E_RD;
			S_EGET:  return OP_E_GET;
			S_ECHK:  return OP_E_CHK;
			S_JINIT: return OP_JINIT;
			S_J0RD:  return OP_J0_RD;
			S_J0WR:  return OP_J0_WR;
			S_JKRD1: return OP_JK_RD1;
			S_JKRD2: return OP_JK_RD2;
			S_JKWR:  return OP_JK_WR;
			S_QRDA:  return OP_Q_RDA;
			S_QRDB:  return OP_Q_RDB;
			S_QORD:  return OP_Q_ORD;
			S_L1RD:  return OP_L1_RD;
			S_L1G:   return OP_L1_GET;
			S_L2RU:  return OP_L2_RDU;
			S_L2RV:  return OP_L2_RDV;
			S_L2G:   return OP_L2_GET;
			S_PRD:   return OP_PAR_RD;
			S_OPAR:  return OP_OUT_PAR;
			S_OEQ:   return OP_OUT_EQ;
			S_OERR:  return OP_OUT_ERR;
			default: return OP_NOP;
		endcase
	endfunction

	assign accept = start && !busy_q;

	always_comb begin
		nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_EDGE:  nxt = S_EDGE;
						MODE_BUILD: nxt = S_CLR;
						MODE_QUERY: nxt = S_QCHK;
						default:    nxt = S_IDLE;
					endcase
				end
			end
			S_EDGE:  nxt = S_IDLE;
			S_CLR:   nxt = stat.clr_last ? S_ROOT : S_CLR;
			S_ROOT:  nxt = S_POP;
			S_QTEST: nxt = stat.q_empty ? S_JINIT : S_POP;
			S_POP:   nxt = S_POPG;
			S_POPG:  nxt = S_DXG;
			S_DXG:   nxt = S_ETEST;
			S_ETEST: nxt = stat.e_end ? S_QTEST : S_ERD;
			S_ERD:   nxt = S_EGET;
			S_EGET:  nxt = S_ECHK;
			S_ECHK:  nxt = S_ETEST;
			S_JINIT: nxt = S_J0RD;
			S_J0RD:  nxt = S_J0WR;
			S_J0WR: begin
				if (!stat.i_last) begin
					nxt = S_J0RD;
				end else if (LOG_LEVELS > 1) begin
					nxt = S_JKRD1;
				end else begin
					nxt = S_IDLE;
				end
			end
			S_JKRD1: nxt = S_JKRD2;
			S_JKRD2: nxt = S_JKWR;
			S_JKWR:  nxt = (stat.i_last && stat.k_last) ? S_IDLE : S_JKRD1;
			S_QCHK:  nxt = stat.bad ? S_OERR : S_QRDA;
			S_QRDA:  nxt = S_QRDB;
			S_QRDB:  nxt = S_QORD;
			S_QORD:  nxt = S_L1RD;
			S_L1RD:  nxt = S_L1G;
			S_L1G:   nxt = stat.lvl_zero ? S_CMP : S_L1RD;
			S_CMP:   nxt = stat.u_eq_v ? S_OEQ : S_L2RU;
			S_L2RU:  nxt = S_L2RV;
			S_L2RV:  nxt = S_L2G;
			S_L2G:   nxt = stat.lvl_zero ? S_PRD : S_L2RU;
			S_PRD:   nxt = S_OPAR;
			S_OPAR:  nxt = S_IDLE;
			S_OEQ:   nxt = S_IDLE;
			S_OERR:  nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_NOP;
			busy_q <= 1'b0;
		end else begin
			state_q <= nxt;
			op_q <= op_for(nxt);
			busy_q <= nxt != S_IDLE;
		end
	end

	assign cmd.op = op_q;
	assign cmd.accept = accept;
	assign busy = busy_q;

endmodule

// ----- src/lowest_common_ancestor_lifting.sv -----
// top level of the lowest common ancestor engine (binary lifting)
// joins lcal_ctrl and lcal_datapath; depends on lcal_pkg
`timescale 1ns / 1ps

// usage
// - command channel: a transaction is taken at a clock edge with start high
//   and busy low; item.mode picks edge load, table build or query
// - result channel: done is high for one cycle with result valid; only a
//   query gives a result, and the receiver cannot hold it off
// - node_count is written through cfg_we / cfg_wdata while idle, saturated
//   into 2..MAX_NODES
// operation
// - edge load stores one edge while the store holds fewer than MAX_NODES-1
// - query: the deeper node is lifted level by level from L down to 0, L =
//   min(LOG_LEVELS-1, floor(log2 depth of the deeper node)); unless the nodes
//   then meet, both climb together over the same levels; the jump memory has a
//   single read port, read once per node per level; a bad node id gives an error
// - build: clears entries 0..MAX_NODES, marks node 1 as root, then searches
//   from it breadth-first, scanning every stored edge for each reached node,
//   then fills the jump memory level by level for nodes 1..n
// - done rises in the cycle in which busy drops; a new command may be taken
//   at the end of that cycle
// reset clears the edge count, node_count (to 2) and the sequencer; tables
// hold nothing valid until the first build

module lowest_common_ancestor_lifting import lcal_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int LOG_LEVELS = LOG_LEVELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  in_item_t        item,
	input  logic            cfg_we,
	input  logic [ID_W-1:0] cfg_wdata,
	output logic            done,
	output out_item_t       result
);

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	lcal_ctrl #(
		.LOG_LEVELS(LOG_LEVELS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(item.mode),
		.stat(stat),
		.cmd(cmd),
		.busy(busy)
	);

	lcal_datapath #(
		.MAX_NODES(MAX_NODES),
		.LOG_LEVELS(LOG_LEVELS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.stat(stat),
		.result(result),
		.done(done)
	);

endmodule

// ----- src/lcal_checker.sv -----
// port-level checks for the lowest common ancestor engine, bound to the top
// depends on lcal_pkg
`timescale 1ns / 1ps

module lcal_checker import lcal_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  item,
	input logic      done,
	input out_item_t result
);

	// a result comes out only after the engine has worked on a transaction
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode != MODE_NONE) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.error) |-> (result.ancestor == '0))
		else $error("error result carries a node id");

endmodule

bind lowest_common_ancestor_lifting lcal_checker u_lcal_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.item(item),
	.done(done),
	.result(result)
);

// ----- tb/tb_lowest_common_ancestor_lifting.sv -----
// testbench for the binary-lifting lowest common ancestor engine
// drives edge loads, table builds and queries, predicts each answer; depends on lcal_pkg
`timescale 1ns / 1ps

module tb_lowest_common_ancestor_lifting;
	import lcal_pkg::*;

	localparam int NODES = 1024;
	localparam int LEVELS = 10;
	localparam int EDGE_CAP = NODES - 1;
	localparam longint CYCLE_LIMIT = 12_000_000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      cfg_we;
	logic [ID_W-1:0] cfg_wdata;
	logic      done;
	out_item_t result;

	// shadow copy of the engine state
	int        sh_count;
	int        sh_edge_a [EDGE_CAP];
	int        sh_edge_b [EDGE_CAP];
	int        sh_edges;
	int        sh_parent [NODES+1];
	int        sh_depth [NODES+1];
	int        sh_jump [NODES+1][LEVELS];

	// answers still owed by the engine
	out_item_t pending_answers[$];
	int        mismatches;
	longint    cycles;

	lowest_common_ancestor_lifting dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.result   (result)
	);

	always #1 clk = ~clk;

	// runaway guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_lowest_common_ancestor_lifting: done, errors");
			$finish;
		end
	end

	// breadth-first search from node 1, then the doubling table
	task automatic grow_tables();
		int fifo[$];
		bit seen [NODES+1];
		int x;
		int y;
		int mid;
		for (int i = 0; i <= NODES; i++) begin
			seen[i] = 0;
			sh_parent[i] = 0;
			sh_depth[i] = 0;
		end
		fifo.insert(fifo.size(), 1);
		seen[1] = 1;
		while (fifo.size() > 0) begin
			x = fifo.pop_front();
			for (int e = 0; e < sh_edges; e++) begin
				if (sh_edge_a[e] == x) y = sh_edge_b[e];
				else if (sh_edge_b[e] == x) y = sh_edge_a[e];
				else continue;
				if (y < 1 || y > sh_count || seen[y]) continue;
				seen[y] = 1;
				sh_parent[y] = x;
				sh_depth[y] = sh_depth[x] + 1;
				fifo.insert(fifo.size(), y);
			end
		end
		for (int i = 1; i <= sh_count; i++)
			sh_jump[i][0] = sh_parent[i];
		for (int k = 1; k < LEVELS; k++) begin
			for (int i = 1; i <= sh_count; i++) begin
				mid = sh_jump[i][k-1];
				sh_jump[i][k] = (mid != 0) ? sh_jump[mid][k-1] : 0;
			end
		end
	endtask

	function automatic int meet_point(int u, int v);
		int top;
		int t;
		int pu;
		int pv;
		top = 0;
		if (sh_depth[u] < sh_depth[v]) begin
			t = u;
			u = v;
			v = t;
		end
		while (top + 1 < LEVELS && (1 << (top + 1)) <= sh_depth[u])
			top++;
		// bring the deeper node up to the other's depth
		for (int i = top; i >= 0; i--)
			if (sh_depth[u] >= sh_depth[v] + (1 << i)) u = sh_jump[u][i];
		if (u == v) return u;
		// climb together while the ancestors still differ
		for (int i = top; i >= 0; i--) begin
			pu = sh_jump[u][i];
			pv = sh_jump[v][i];
			if (pu != 0 && pu != pv) begin
				u = pu;
				v = pv;
			end
		end
		return sh_parent[u];
	endfunction

	// advance the shadow state by one accepted transaction
	task automatic apply_item(in_item_t it);
		out_item_t ans;
		int a;
		int b;
		a = it.node_a;
		b = it.node_b;
		case (it.mode)
			MODE_EDGE: begin
				if (sh_edges < EDGE_CAP) begin
					sh_edge_a[sh_edges] = a;
					sh_edge_b[sh_edges] = b;
					sh_edges++;
				end
			end
			MODE_BUILD: begin
				grow_tables();
			end
			MODE_QUERY: begin
				if (a < 1 || a > sh_count || b < 1 || b > sh_count) begin
					ans.ancestor = '0;
					ans.error = 1'b1;
				end else begin
					ans.ancestor = ID_W'(meet_point(a, b));
					ans.error = 1'b0;
				end
				pending_answers.insert(pending_answers.size(), ans);
			end
			default: begin
			end
		endcase
	endtask

	// random idle before a transaction: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(logic [1:0] mode, int a, int b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.mode = mode;
		item.node_a = ID_W'(a);
		item.node_b = ID_W'(b);
		start = 1'b1;
		do @(posedge clk); while (busy);
		apply_item(item);
		@(negedge clk);
	endtask

	// wait until every answer is in and the engine has gone quiet
	task automatic settle();
		start = 1'b0;
		@(negedge clk);
		while (pending_answers.size() > 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_node_count(int value);
		int v;
		settle();
		cfg_we = 1'b1;
		cfg_wdata = ID_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		v = value & 11'h7FF;
		if (v < 2) v = 2;
		if (v > NODES) v = NODES;
		sh_count = v;
	endtask

	// result checker: the engine cannot be held off, so take every strobe
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result ancestor=%0d error=%0b", result.ancestor, result.error);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (result.ancestor !== want.ancestor) begin
					$error("ancestor: expected %0d, got %0d", want.ancestor, result.ancestor);
					mismatches++;
				end
				if (result.error !== want.error) begin
					$error("error: expected %0b, got %0b", want.error, result.error);
					mismatches++;
				end
			end
		end
	end

	// small hand-built tree with every special case
	task automatic test_small_tree();
		set_node_count(8);
		send_item(MODE_EDGE, 1, 2);
		send_item(MODE_EDGE, 3, 2);
		send_item(MODE_EDGE, 3, 4);
		send_item(MODE_EDGE, 1, 5);
		send_item(MODE_EDGE, 5, 6);
		send_item(MODE_EDGE, 9, 1);     // endpoint beyond node_count
		send_item(MODE_EDGE, 0, 7);     // node 7 stays unreached
		send_item(MODE_NONE, 2047, 2047);
		send_item(MODE_BUILD, 0, 0);
		send_item(MODE_QUERY, 4, 6);
		send_item(MODE_QUERY, 6, 4);
		send_item(MODE_QUERY, 4, 4);
		send_item(MODE_QUERY, 3, 2);
		send_item(MODE_QUERY, 1, 1);
		send_item(MODE_QUERY, 4, 1);
		send_item(MODE_QUERY, 0, 3);
		send_item(MODE_QUERY, 3, 9);
		send_item(MODE_QUERY, 2047, 1);
		send_item(MODE_QUERY, 7, 3);    // different components
		send_item(MODE_QUERY, 7, 8);
		send_item(MODE_QUERY, 8, 8);
		send_item(MODE_QUERY, 8, 2047);
		send_item(MODE_NONE, 0, 0);
	endtask

	// register extremes, including saturation below and above
	task automatic test_count_extremes();
		set_node_count(0);
		send_item(MODE_BUILD, 0, 0);
		send_item(MODE_QUERY, 1, 2);
		send_item(MODE_QUERY, 2, 2);
		send_item(MODE_QUERY, 3, 1);
		set_node_count(1);
		send_item(MODE_BUILD, 0, 0);
		send_item(MODE_QUERY, 2, 1);
		set_node_count(2047);
		send_item(MODE_BUILD, 0, 0);
		send_item(MODE_QUERY, 1024, 1);
		send_item(MODE_QUERY, 1025, 1);
		send_item(MODE_QUERY, 1024, 1023);
	endtask

	// random trees on top of the edges already stored, then many queries
	task automatic test_random_trees();
		int n;
		int base;
		int r;
		int a;
		int b;
		for (int round = 0; round < 11; round++) begin
			if (round == 2) n = 130;
			else if (round == 6) n = 1024;
			else n = $urandom_range(3, 24);
			set_node_count(n);
			if (n == 1024) begin
				// sparse: a handful of branches hung from the root
				for (int e = 0; e < 50; e++) begin
					a = (e < 8) ? 1 : $urandom_range(1, 1024);
					send_item(MODE_EDGE, a, $urandom_range(1, 1024));
				end
			end else begin
				for (int i = 2; i <= n; i++) begin
					base = (round == 2) ? i - 1 : $urandom_range(1, i - 1);
					if ($urandom_range(1)) send_item(MODE_EDGE, i, base);
					else send_item(MODE_EDGE, base, i);
				end
			end
			send_item(MODE_BUILD, 0, 0);
			for (int q = 0; q < 55; q++) begin
				r = $urandom_range(99);
				if (r < 80) begin
					send_item(MODE_QUERY, $urandom_range(1, n), $urandom_range(1, n));
				end else if (r < 88) begin
					a = $urandom_range(1) ? 0 : $urandom_range(n + 1, 2047);
					b = $urandom_range(2047);
					if ($urandom_range(1)) send_item(MODE_QUERY, a, b);
					else send_item(MODE_QUERY, b, a);
				end else if (r < 92) begin
					send_item(MODE_NONE, $urandom_range(2047), $urandom_range(2047));
				end else if (r < 95) begin
					send_item(MODE_EDGE, $urandom_range(2047), $urandom_range(2047));
				end else if (r < 97) begin
					send_item(MODE_BUILD, $urandom_range(2047), $urandom_range(2047));
				end else begin
					settle();   // hold off until the engine has answered everything
				end
			end
		end
	endtask

	// fill the edge store past capacity; the extra edges must be dropped
	task automatic test_store_full();
		set_node_count(6);
		while (sh_edges < EDGE_CAP)
			send_item(MODE_EDGE, $urandom_range(7, 2047), $urandom_range(2047));
		send_item(MODE_EDGE, 1, 6);
		send_item(MODE_EDGE, 6, 2);
		send_item(MODE_BUILD, 0, 0);
		for (int q = 0; q < 30; q++)
			send_item(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 7));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycles = 0;
		mismatches = 0;
		sh_count = 2;
		sh_edges = 0;
		for (int i = 0; i <= NODES; i++) begin
			sh_parent[i] = 0;
			sh_depth[i] = 0;
			for (int k = 0; k < LEVELS; k++) sh_jump[i][k] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_small_tree();
		test_count_extremes();
		test_random_trees();
		test_store_full();

		settle();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("tb_lowest_common_ancestor_lifting: done, clean");
		end else begin
			$display("tb_lowest_common_ancestor_lifting: done, errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/lcal_pkg.sv
src/lcal_datapath.sv
src/lcal_ctrl.sv
src/lowest_common_ancestor_lifting.sv
src/lcal_checker.sv
tb/tb_lowest_common_ancestor_lifting.sv
